>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/lsch_pkg.sv
// Package with constants, types and codes of the lottery scheduler.
package lsch_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int TICK_W      = 16;
  localparam int ARR_W       = 32;
  localparam int TOT_W       = ADDR_W + TICK_W;
  localparam int LCG_W       = 31;
  localparam int CNT_W       = $clog2(LCG_W + 1);

  localparam logic [LCG_W-1:0] LCG_MUL  = 31'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD  = 31'd12345;
  localparam logic [LCG_W-1:0] LCG_SEED = 31'd1;

  typedef struct packed {
    logic              runnable;
    logic [TICK_W-1:0] tickets;
    logic [ARR_W-1:0]  arrival;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DRAW  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SUM,
    ST_CHK,
    ST_DIV,
    ST_LCG,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Handshake between the sequencer and the remainder unit.
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

>>> rtl/core/lottery_scheduler.sv
// Lottery scheduler. After reset the block sweeps its entry table to zero,
// one entry per cycle, and accepts no transaction meanwhile. A write
// returns its all-zero result on the cycle after it is taken. A draw reads
// the table once to sum runnable tickets, checks the total, runs a 31-step
// bit-serial remainder of the random state by that total, advances the
// generator, reads the table a second time to pick the winner and clears its
// runnable flag in a final state. A draw with no runnable tickets ends after
// the first pass. One transaction is in flight at a time; a stalled result
// holds off the next transaction, which is taken in the cycle that the result
// leaves.
module lottery_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [5:0]                  entry_index,
  input  logic                        runnable,
  input  logic [15:0]                 tickets,
  input  logic [31:0]                 arrival_tick,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        granted,
  output logic [5:0]                  winner_index,
  output logic [21:0]                 drawn_ticket,
  output logic [21:0]                 ticket_total
);
  import lsch_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_ENTRIES - 1);

  state_t            state, state_next;
  logic [ADDR_W-1:0] cnt;
  logic              issuing;
  logic              pend;
  logic [ADDR_W-1:0] pidx;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  win;
  logic [TOT_W-1:0]  run;
  logic [TOT_W-1:0]  run_next;
  logic [LCG_W-1:0]  lcg;
  logic [LCG_W-1:0]  lcg_prod;
  logic              have;
  logic [ADDR_W-1:0] sel_idx;
  logic [TICK_W-1:0] sel_tickets;
  logic [ARR_W-1:0]  sel_arrival;
  logic              in_acc;
  logic              out_free;
  logic              last_data;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd;
  logic [TOT_W-1:0]  rem;
  div_ctl_t          div_in, div_out;
  entry_t            new_entry;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign last_data = pend && (pidx == LAST);
  assign run_next  = run + TOT_W'(rd.tickets);
  assign lcg_prod  = LCG_W'(LCG_MUL * lcg);
  assign div_in.start = (state == ST_CHK) && (total != '0);
  assign div_in.done  = 1'b0;

  assign new_entry.runnable = runnable;
  assign new_entry.tickets  = tickets;
  assign new_entry.arrival  = arrival_tick;

  // Select the write source: clearing sweep, table write, winner clear.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    case (state)
      ST_CLR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_we    = in_acc && (op_t'(opcode) == OP_WRITE) &&
                    (32'(entry_index) < 32'(NUM_ENTRIES));
        ram_waddr = ADDR_W'(entry_index);
        ram_wdata = new_entry;
      end
      ST_DONE: begin
        ram_we             = have;
        ram_waddr          = sel_idx;
        ram_wdata.runnable = 1'b0;
        ram_wdata.tickets  = sel_tickets;
        ram_wdata.arrival  = sel_arrival;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lsch_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt),
    .rdata(rd)
  );

  lsch_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_in),
    .dividend (lcg),
    .divisor  (total),
    .ctl_out  (div_out),
    .remainder(rem)
  );

  // Hold the sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the draw phases.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:  if (cnt == LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && op_t'(opcode) == OP_DRAW) state_next = ST_SUM;
      end
      ST_SUM:  if (last_data) state_next = ST_CHK;
      ST_CHK:  state_next = (total == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (div_out.done) state_next = ST_LCG;
      ST_LCG:  state_next = ST_SCAN;
      ST_SCAN: if (last_data) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequence addresses, accumulate, and pick the winner.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      issuing <= 1'b0;
      pend    <= 1'b0;
      lcg     <= LCG_SEED;
      have    <= 1'b0;
    end else begin
      pend <= issuing;
      pidx <= cnt;
      if (state == ST_CLR && cnt != LAST) begin
        cnt <= cnt + 1'b1;
      end
      if (issuing) begin
        if (cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (state == ST_IDLE && in_acc && op_t'(opcode) == OP_DRAW) begin
        cnt     <= '0;
        issuing <= 1'b1;
        total   <= '0;
        win     <= '0;
        have    <= 1'b0;
      end
      if (state == ST_SUM && pend && rd.runnable) begin
        total <= total + TOT_W'(rd.tickets);
      end
      if (state == ST_DIV && div_out.done) begin
        win <= rem + 1'b1;
      end
      if (state == ST_LCG) begin
        lcg     <= lcg_prod + LCG_ADD;
        cnt     <= '0;
        issuing <= 1'b1;
        run     <= '0;
      end
      if (state == ST_SCAN && pend && rd.runnable) begin
        run <= run_next;
        if (run_next >= win) begin
          if (!have || (rd.tickets == sel_tickets && rd.arrival < sel_arrival)) begin
            have        <= 1'b1;
            sel_idx     <= pidx;
            sel_tickets <= rd.tickets;
            sel_arrival <= rd.arrival;
          end
        end
      end
    end
  end

  // Load the output register; drop valid once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc && op_t'(opcode) == OP_WRITE) begin
        out_valid    <= 1'b1;
        granted      <= 1'b0;
        winner_index <= '0;
        drawn_ticket <= '0;
        ticket_total <= '0;
      end else if (state == ST_DONE && out_free) begin
        out_valid    <= 1'b1;
        granted      <= have;
        winner_index <= have ? 6'(sel_idx) : '0;
        drawn_ticket <= have ? 22'(win) : '0;
        ticket_total <= 22'(total);
      end
    end
  end

endmodule

>>> rtl/core/lsch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the array; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lsch_mod.sv
// Restoring remainder unit: one quotient bit per cycle.
module lsch_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  lsch_pkg::div_ctl_t        ctl_in,
  input  logic [lsch_pkg::LCG_W-1:0] dividend,
  input  logic [lsch_pkg::TOT_W-1:0] divisor,
  output lsch_pkg::div_ctl_t        ctl_out,
  output logic [lsch_pkg::TOT_W-1:0] remainder
);
  import lsch_pkg::*;

  logic [LCG_W-1:0] dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [TOT_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and test against the divisor.
  assign trial = {remainder, dvd[LCG_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  assign ctl_out = '{start: 1'b0, done: done};

  // Step through the dividend bits, top first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        dvd       <= dividend;
        remainder <= '0;
      end else if (busy) begin
        remainder <= fits ? TOT_W'(trial - {1'b0, divisor}) : TOT_W'(trial);
        dvd       <= {dvd[LCG_W-2:0], 1'b0};
        if (cnt == CNT_W'(LCG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/lsch_checker.sv
// Port-level checker for the lottery scheduler, bound to the top level.
`include "assert_macros.svh"

module lsch_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        granted,
  input logic [5:0]  winner_index,
  input logic [21:0] drawn_ticket,
  input logic [21:0] ticket_total
);
  import lsch_pkg::*;

  logic wr_acc;
  logic wr_res;

  assign wr_acc = in_valid && !in_stall && op_t'(opcode) == OP_WRITE;
  assign wr_res = out_valid && !granted && ticket_total == 22'd0;

  // A stalled result stays presented.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // A write transaction yields an all-zero result on the next cycle.
  `ASSERT_NEXT(a_write_res, clk, rst, wr_acc, wr_res)
  // A miss carries no winner and no ticket.
  `ASSERT_NOW(a_miss_zero, clk, rst, out_valid && !granted, winner_index == 6'd0 && drawn_ticket == 22'd0)
  // A grant draws a ticket within the total.
  `ASSERT_NOW(a_grant_range, clk, rst, out_valid && granted, drawn_ticket != 22'd0 && drawn_ticket <= ticket_total)

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for the lottery scheduler: directed table, then random traffic.
module tb;
  import lsch_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 1030;
  localparam int SQUEEZE_LEN = 600;

  typedef struct packed {
    logic        granted;
    logic [5:0]  winner_index;
    logic [21:0] drawn_ticket;
    logic [21:0] ticket_total;
  } grant_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  idx;
    logic        run;
    logic [15:0] tk;
    logic [31:0] arr;
    logic        typed;
    grant_t      known;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [5:0]  entry_index;
  logic        runnable;
  logic [15:0] tickets;
  logic [31:0] arrival_tick;
  logic        out_valid;
  logic        out_stall;
  logic        granted;
  logic [5:0]  winner_index;
  logic [21:0] drawn_ticket;
  logic [21:0] ticket_total;

  lottery_scheduler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .entry_index(entry_index), .runnable(runnable),
    .tickets(tickets), .arrival_tick(arrival_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted(granted), .winner_index(winner_index),
    .drawn_ticket(drawn_ticket), .ticket_total(ticket_total)
  );

  // Shadow copy of the scheduler state
  logic              shadow_run [NUM_ENTRIES];
  logic [15:0]       shadow_tk  [NUM_ENTRIES];
  logic [31:0]       shadow_arr [NUM_ENTRIES];
  logic [LCG_W-1:0]  shadow_lcg;

  grant_t pending_grants[$];
  int     errors;
  int     n_writes, n_draws, n_grants, n_checked;
  bit     stim_done;
  bit     squeeze_req;

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  // Apply one transaction to the shadow state and return the expected result
  function automatic grant_t lottery_outcome(op_t op, logic [5:0] idx, logic run,
                                             logic [15:0] tk, logic [31:0] arr);
    grant_t      g;
    logic [31:0] total;
    logic [31:0] win;
    logic [31:0] acc;
    int          pick;
    g = '0;
    if (op == OP_WRITE) begin
      shadow_run[idx] = run;
      shadow_tk[idx]  = tk;
      shadow_arr[idx] = arr;
      return g;
    end
    total = 0;
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (shadow_run[i]) total += shadow_tk[i];
    if (total == 0) return g;
    win = ({1'b0, shadow_lcg} % total) + 1;
    shadow_lcg = LCG_W'(LCG_MUL * shadow_lcg + LCG_ADD);
    acc  = 0;
    pick = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!shadow_run[i]) continue;
      acc += shadow_tk[i];
      if (acc >= win) begin
        if (pick < 0) pick = i;
        else if (shadow_tk[i] == shadow_tk[pick] && shadow_arr[i] < shadow_arr[pick])
          pick = i;
      end
    end
    g.ticket_total = total[21:0];
    if (pick < 0) return g;
    shadow_run[pick]  = 1'b0;
    g.granted        = 1'b1;
    g.winner_index   = pick[5:0];
    g.drawn_ticket   = win[21:0];
    return g;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Drive one transaction and hold it until accepted
  task automatic offer(op_t op, logic [5:0] idx, logic run, logic [15:0] tk,
                       logic [31:0] arr, logic typed, grant_t known);
    grant_t g;
    in_valid     <= 1'b1;
    opcode       <= op;
    entry_index  <= idx;
    runnable     <= run;
    tickets      <= tk;
    arrival_tick <= arr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = lottery_outcome(op, idx, run, tk, arr);
    if (typed) g = known;
    pending_grants.push_back(g);
    if (op == OP_WRITE) n_writes++;
    else n_draws++;
  endtask

  row_t directed[$];
  int   burst_left;

  function automatic row_t mk(op_t op, logic [5:0] idx, logic run, logic [15:0] tk,
                              logic [31:0] arr, logic typed, grant_t known);
    row_t r;
    r.op = op; r.idx = idx; r.run = run; r.tk = tk; r.arr = arr;
    r.typed = typed; r.known = known;
    return r;
  endfunction

  // Stimulus: directed table, then random traffic in bursts
  initial begin
    row_t        r;
    grant_t      z;
    op_t         op;
    logic [5:0]  idx;
    logic        run;
    logic [15:0] tk;
    logic [31:0] arr;
    int          sel;
    z = '0;
    rst = 1'b1; in_valid = 1'b0; opcode = 1'b0; entry_index = '0; runnable = 1'b0;
    tickets = '0; arrival_tick = '0;
    errors = 0; n_writes = 0; n_draws = 0; n_grants = 0; n_checked = 0;
    stim_done = 1'b0; squeeze_req = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_run[i] = 1'b0; shadow_tk[i] = '0; shadow_arr[i] = '0;
    end
    shadow_lcg = LCG_W'(1);

    // empty table, extremes, zero-ticket runnable, tie break on arrival
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 1, z));
    directed.push_back(mk(OP_WRITE, 0, 1, 16'hFFFF, 32'hFFFFFFFF, 1, z));
    directed.push_back(mk(OP_WRITE, 63, 0, 16'hFFFF, 0, 1, z));
    directed.push_back(mk(OP_DRAW, 63, 1, 16'hFFFF, 32'hFFFFFFFF, 1,
                          grant_t'({1'b1, 6'd0, 22'd2, 22'd65535})));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 1, z));
    directed.push_back(mk(OP_WRITE, 63, 1, 0, 0, 1, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 1, z));
    directed.push_back(mk(OP_WRITE, 5, 1, 10, 100, 1, z));
    directed.push_back(mk(OP_WRITE, 6, 1, 10, 50, 1, z));
    directed.push_back(mk(OP_WRITE, 7, 1, 10, 50, 1, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_WRITE, 0, 1, 16'hFFFF, 0, 1, z));
    directed.push_back(mk(OP_WRITE, 1, 1, 1, 32'hFFFFFFFF, 1, z));
    directed.push_back(mk(OP_WRITE, 2, 0, 7, 3, 1, z));
    directed.push_back(mk(OP_WRITE, 42, 1, 16'h5555, 32'hAAAAAAAA, 1, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));
    directed.push_back(mk(OP_DRAW, 0, 0, 0, 0, 0, z));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      r = directed[i];
      offer(r.op, r.idx, r.run, r.tk, r.arr, r.typed, r.known);
    end

    // random traffic: mostly writes with clustered values to provoke ties
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) squeeze_req = 1'b1;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 20);
      end
      burst_left--;
      op  = ($urandom_range(0, 99) < 35) ? OP_DRAW : OP_WRITE;
      idx = $urandom_range(0, 63);
      run = ($urandom_range(0, 99) < 85);
      sel = $urandom_range(0, 99);
      if (sel < 5) tk = 16'd0;
      else if (sel < 15) tk = 16'hFFFF;
      else if (sel < 50) tk = $urandom_range(1, 8);
      else tk = $urandom;
      arr = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 3) : $urandom;
      offer(op, idx, run, tk, arr, 1'b0, z);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: changing stall pattern, plus one long hold-off
  int rx_cyc, squeeze_left;
  bit squeeze_done;
  initial begin
    out_stall = 1'b0; rx_cyc = 0; squeeze_left = 0; squeeze_done = 1'b0;
  end
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (squeeze_req && !squeeze_done) begin
      squeeze_done <= 1'b1;
      squeeze_left <= SQUEEZE_LEN;
      out_stall    <= 1'b1;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
      out_stall    <= 1'b1;
    end else begin
      case ((rx_cyc / 250) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= (rx_cyc % 7) < 3;
        default: out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_grants.pop_front();
        n_checked++;
        if (granted) n_grants++;
        if (granted != want.granted) report_mismatch("granted", granted, want.granted);
        if (winner_index != want.winner_index)
          report_mismatch("winner_index", winner_index, want.winner_index);
        if (drawn_ticket != want.drawn_ticket)
          report_mismatch("drawn_ticket", drawn_ticket, want.drawn_ticket);
        if (ticket_total != want.ticket_total)
          report_mismatch("ticket_total", ticket_total, want.ticket_total);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  int idle_cycles;
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_grants.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drain and report
  initial begin
    wait (stim_done);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d writes and %0d draws, %0d granted, %0d results checked",
             n_writes, n_draws, n_grants, n_checked);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_grants.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
